>>> hw/rtl/round_robin_sleep_scheduler_macros.svh
// assertion helpers used by the checker file
`ifndef ROUND_ROBIN_SLEEP_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_SLEEP_SCHEDULER_MACROS_SVH

// property that must hold at every edge outside reset
`define RRSS_ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define RRSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/rrss_pkg.sv
`timescale 1ns / 1ps

package rrss_pkg;

   localparam int TICKS_W     = 16;
   localparam int SLICE_W     = 8;
   localparam int OUT_IDX_W   = 6;
   localparam int KIND_W      = 2;
   localparam int RSP_W       = 16;
   localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd16;

   typedef enum logic [1:0] {
      ST_DEAD     = 2'd0,
      ST_BLOCKED  = 2'd1,
      ST_RUNNABLE = 2'd2,
      ST_RUNNING  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_SLEEP = 2'd1,
      KIND_EXIT  = 2'd2,
      KIND_FORK  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ALU_TICK_OTHER,
      ALU_TICK_CUR,
      ALU_CLAIM
   } alu_op_type;

   typedef struct packed {
      alu_op_type           op;
      kind_type             kind;
      logic [SLICE_W-1:0]   time_slice;
   } alu_ctl_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_WALK,
      SEQ_SWITCH,
      SEQ_DONE
   } seq_state_type;

endpackage

>>> hw/rtl/round_robin_sleep_scheduler.sv
`timescale 1ns / 1ps

// Round robin task scheduler with sleep countdowns and a time slice. Each request transaction
// is an event (tick, sleep, exit or fork) and gives exactly one response transaction with
// the current slot, its status, whether the current slot changed, and the fork outcome.
// The per-slot records live in a single-port-read memory, and one shared slot update unit
// walks them one slot per cycle: a tick, sleep or exit visits every slot starting after the
// current one and ending on it, and passes through SEQ_SWITCH before the response is loaded
// when the scheduler switches to another slot; a fork walks from slot 1 and stops at the
// first dead slot or at the last slot; a sleep of zero ticks goes straight to SEQ_DONE.
// The block accepts one request at a time and is ready again in the cycle after the response
// is loaded, even if that response is still waiting on rsp_tready.
// No clearing pass is needed after reset. time_slice is written through csr_we/csr_wdata
// and must only change while the block is idle.

module round_robin_sleep_scheduler #(
   parameter int SLOTS      = 4,
   parameter int SLEEP_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [rrss_pkg::TICKS_W-1:0]  req_tdata,   // [15:0] sleep_ticks
   input  logic [rrss_pkg::KIND_W-1:0]   req_tuser,   // [1:0] kind
   // response channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [rrss_pkg::RSP_W-1:0]    rsp_tdata,   // [5:0] running_slot, [7:6] current_status,
                                                      // [8] switched, [9] fork_ok,
                                                      // [15:10] child_slot
   // configuration
   input  logic                          csr_we,
   input  logic [rrss_pkg::SLICE_W-1:0]  csr_wdata    // time_slice
);
   import rrss_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int REC_W = 2 + SLEEP_BITS + SLICE_W;
   localparam int EXT_W = (SLEEP_BITS > TICKS_W) ? SLEEP_BITS : TICKS_W;

   // sequencer state
   seq_state_type            state_ff, state_in;
   kind_type                 kind_ff, kind_in;
   logic [SLEEP_BITS-1:0]    sleep_len_ff, sleep_len_in;
   logic [IDX_W-1:0]         cur_ff, cur_in;
   status_type               cur_st_ff, cur_st_in;
   logic [IDX_W-1:0]         rd_addr_ff, rd_addr_in;
   logic [CNT_W-1:0]         issue_cnt_ff, issue_cnt_in;
   logic                     pv_ff, pv_in;          // read data in flight is valid
   logic [IDX_W-1:0]         pa_ff, pa_in;          // slot of the read data
   logic                     found_ff, found_in;
   logic [IDX_W-1:0]         nxt_ff, nxt_in;
   logic [SLEEP_BITS-1:0]    nxt_sleep_ff, nxt_sleep_in;
   logic [SLICE_W-1:0]       nxt_slice_ff, nxt_slice_in;
   logic                     switched_ff, switched_in;
   logic                     fork_ok_ff, fork_ok_in;
   logic [IDX_W-1:0]         child_ff, child_in;
   logic [SLICE_W-1:0]       time_slice_ff;
   logic                     rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_W-1:0]         rsp_tdata_ff, rsp_tdata_in;

   // memory port signals
   logic                     mem_wr_en;
   logic [IDX_W-1:0]         mem_wr_addr;
   logic [REC_W-1:0]         mem_wr_data;
   logic                     mem_rd_en;
   logic [REC_W-1:0]         mem_rd_data;
   logic                     mem_rd_written;

   // slot record as read, reset value substituted for unwritten entries
   status_type               rec_st;
   logic [SLEEP_BITS-1:0]    rec_sleep;
   logic [SLICE_W-1:0]       rec_slice;

   // shared update unit
   alu_ctl_type              alu_ctl;
   status_type               alu_st;
   logic [SLEEP_BITS-1:0]    alu_sleep;
   logic [SLICE_W-1:0]       alu_slice;

   logic [IDX_W-1:0]         rd_addr_inc;
   logic [IDX_W-1:0]         cur_inc;
   logic [CNT_W-1:0]         issue_total;
   logic [EXT_W-1:0]         ticks_ext;
   logic [EXT_W-1:0]         sleep_max_ext;
   logic [SLEEP_BITS-1:0]    sleep_sat;
   kind_type                 req_kind;

   assign req_kind      = kind_type'(req_tuser);
   assign ticks_ext     = EXT_W'(req_tdata);
   assign sleep_max_ext = EXT_W'({SLEEP_BITS{1'b1}});
   // a sleep length wider than the countdown saturates
   assign sleep_sat     = (ticks_ext > sleep_max_ext) ? {SLEEP_BITS{1'b1}}
                                                      : ticks_ext[SLEEP_BITS-1:0];

   // round robin successor, slot count need not be a power of two
   assign rd_addr_inc = (rd_addr_ff == IDX_W'(SLOTS - 1)) ? '0 : rd_addr_ff + 1'b1;
   assign cur_inc     = (cur_ff == IDX_W'(SLOTS - 1)) ? '0 : cur_ff + 1'b1;

   // tick walks all slots, fork walks slots 1 and up
   assign issue_total = (kind_ff == KIND_FORK) ? CNT_W'(SLOTS - 1) : CNT_W'(SLOTS);

   // slot 0 starts running, all others dead with zero counters
   assign rec_st    = mem_rd_written ? status_type'(mem_rd_data[REC_W-1 -: 2])
                                     : ((pa_ff == '0) ? ST_RUNNING : ST_DEAD);
   assign rec_sleep = mem_rd_written ? mem_rd_data[SLICE_W +: SLEEP_BITS] : '0;
   assign rec_slice = mem_rd_written ? mem_rd_data[SLICE_W-1:0] : '0;

   assign alu_ctl.op         = (kind_ff == KIND_FORK) ? ALU_CLAIM
                               : ((pa_ff == cur_ff) ? ALU_TICK_CUR : ALU_TICK_OTHER);
   assign alu_ctl.kind       = kind_ff;
   assign alu_ctl.time_slice = time_slice_ff;

   rrss_slot_alu #(
      .SLEEP_BITS (SLEEP_BITS)
   ) u_alu (
      .ctl       (alu_ctl),
      .sleep_len (sleep_len_ff),
      .st_in     (rec_st),
      .sleep_in  (rec_sleep),
      .slice_in  (rec_slice),
      .st_out    (alu_st),
      .sleep_out (alu_sleep),
      .slice_out (alu_slice)
   );

   rrss_slot_mem #(
      .DEPTH (SLOTS),
      .WIDTH (REC_W)
   ) u_mem (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_data    (mem_wr_data),
      .rd_en      (mem_rd_en),
      .rd_addr    (rd_addr_ff),
      .rd_data    (mem_rd_data),
      .rd_written (mem_rd_written)
   );

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and datapath control
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      sleep_len_in  = sleep_len_ff;
      cur_in        = cur_ff;
      cur_st_in     = cur_st_ff;
      rd_addr_in    = rd_addr_ff;
      issue_cnt_in  = issue_cnt_ff;
      pv_in         = 1'b0;
      pa_in         = rd_addr_ff;
      found_in      = found_ff;
      nxt_in        = nxt_ff;
      nxt_sleep_in  = nxt_sleep_ff;
      nxt_slice_in  = nxt_slice_ff;
      switched_in   = switched_ff;
      fork_ok_in    = fork_ok_ff;
      child_in      = child_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      req_tready    = 1'b0;
      mem_rd_en     = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = pa_ff;
      mem_wr_data   = {alu_st, alu_sleep, alu_slice};

      unique case (state_ff)
         SEQ_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               kind_in      = req_kind;
               sleep_len_in = sleep_sat;
               found_in     = 1'b0;
               switched_in  = 1'b0;
               fork_ok_in   = 1'b0;
               child_in     = '0;
               issue_cnt_in = '0;
               rd_addr_in   = (req_kind == KIND_FORK) ? IDX_W'(1) : cur_inc;
               // sleep of zero ticks leaves everything as it is
               if (req_kind == KIND_SLEEP && req_tdata == '0) begin
                  state_in = SEQ_DONE;
               end else begin
                  state_in = SEQ_WALK;
               end
            end
         end

         SEQ_WALK: begin
            // read side of the walk
            if (issue_cnt_ff < issue_total) begin
               mem_rd_en    = 1'b1;
               rd_addr_in   = rd_addr_inc;
               issue_cnt_in = issue_cnt_ff + 1'b1;
               pv_in        = 1'b1;
            end
            // update side, one slot behind the read
            if (pv_ff) begin
               if (kind_ff == KIND_FORK) begin
                  if (rec_st == ST_DEAD) begin
                     mem_wr_en  = 1'b1;
                     fork_ok_in = 1'b1;
                     child_in   = pa_ff;
                     if (pa_ff == cur_ff) begin
                        cur_st_in = ST_RUNNABLE;
                     end
                     state_in = SEQ_DONE;
                  end else if (pa_ff == IDX_W'(SLOTS - 1)) begin
                     state_in = SEQ_DONE;
                  end
               end else begin
                  mem_wr_en = 1'b1;
                  if (pa_ff != cur_ff) begin
                     // first runnable slot after current, post countdown
                     if (alu_st == ST_RUNNABLE && !found_ff) begin
                        found_in     = 1'b1;
                        nxt_in       = pa_ff;
                        nxt_sleep_in = alu_sleep;
                        nxt_slice_in = alu_slice;
                     end
                  end else if (alu_st != ST_RUNNING && found_ff) begin
                     state_in = SEQ_SWITCH;
                  end else begin
                     // lone or still running current slot stays
                     cur_st_in = alu_st;
                     state_in  = SEQ_DONE;
                  end
               end
            end
         end

         SEQ_SWITCH: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = nxt_ff;
            mem_wr_data = {ST_RUNNING, nxt_sleep_ff, nxt_slice_ff};
            cur_in      = nxt_ff;
            cur_st_in   = ST_RUNNING;
            switched_in = 1'b1;
            state_in    = SEQ_DONE;
         end

         SEQ_DONE: begin
            // wait for the output register to free up
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {OUT_IDX_W'(child_ff), fork_ok_ff, switched_ff,
                                cur_st_ff, OUT_IDX_W'(cur_ff)};
               state_in      = SEQ_IDLE;
            end
         end

         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff        <= '0;
         cur_st_ff     <= ST_RUNNING;
         pv_ff         <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         time_slice_ff <= SLICE_RESET;
      end else begin
         cur_ff        <= cur_in;
         cur_st_ff     <= cur_st_in;
         pv_ff         <= pv_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_we) begin
            time_slice_ff <= csr_wdata;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      sleep_len_ff <= sleep_len_in;
      rd_addr_ff   <= rd_addr_in;
      issue_cnt_ff <= issue_cnt_in;
      pa_ff        <= pa_in;
      found_ff     <= found_in;
      nxt_ff       <= nxt_in;
      nxt_sleep_ff <= nxt_sleep_in;
      nxt_slice_ff <= nxt_slice_in;
      switched_ff  <= switched_in;
      fork_ok_ff   <= fork_ok_in;
      child_ff     <= child_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

>>> hw/rtl/rrss_slot_alu.sv
`timescale 1ns / 1ps

module rrss_slot_alu #(
   parameter int SLEEP_BITS = 16
) (
   input  rrss_pkg::alu_ctl_type           ctl,
   input  logic [SLEEP_BITS-1:0]           sleep_len,
   input  rrss_pkg::status_type            st_in,
   input  logic [SLEEP_BITS-1:0]           sleep_in,
   input  logic [rrss_pkg::SLICE_W-1:0]    slice_in,
   output rrss_pkg::status_type            st_out,
   output logic [SLEEP_BITS-1:0]           sleep_out,
   output logic [rrss_pkg::SLICE_W-1:0]    slice_out
);
   import rrss_pkg::*;

   always_comb begin
      st_out    = st_in;
      sleep_out = sleep_in;
      slice_out = slice_in;
      unique case (ctl.op) inside
         ALU_CLAIM: begin
            st_out    = ST_RUNNABLE;
            sleep_out = '0;
            slice_out = '0;
         end
         ALU_TICK_OTHER, ALU_TICK_CUR: begin
            // request applied to current slot before the tick
            if (ctl.op == ALU_TICK_CUR) begin
               if (ctl.kind == KIND_SLEEP) begin
                  st_out    = ST_BLOCKED;
                  sleep_out = sleep_len;
               end else if (ctl.kind == KIND_EXIT) begin
                  st_out = ST_DEAD;
               end
            end
            // countdown, wraps from zero
            if (st_out == ST_BLOCKED) begin
               sleep_out = sleep_out - 1'b1;
               if (sleep_out == '0) begin
                  st_out    = ST_RUNNABLE;
                  slice_out = '0;
               end
            end
            // slice aging of the running slot
            if (ctl.op == ALU_TICK_CUR && st_out == ST_RUNNING) begin
               slice_out = slice_out + 1'b1;
               if (slice_out >= ctl.time_slice) begin
                  st_out    = ST_RUNNABLE;
                  slice_out = '0;
               end
            end
         end
         default: begin
            st_out = st_in;
         end
      endcase
   end

endmodule

>>> hw/rtl/rrss_slot_mem.sv
`timescale 1ns / 1ps

module rrss_slot_mem #(
   parameter int DEPTH = 4,
   parameter int WIDTH = 26
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   output logic                     rd_written
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [DEPTH-1:0] written_ff;
   logic [WIDTH-1:0] rd_data_ff;
   logic             rd_written_ff;

   // entry not yet written reads back its reset value in the user
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff    <= ram_ff[rd_addr];
         rd_written_ff <= written_ff[rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign rd_written = rd_written_ff;

endmodule

>>> hw/rtl/rrss_checker.sv
`timescale 1ns / 1ps

`include "round_robin_sleep_scheduler_macros.svh"

module rrss_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [rrss_pkg::RSP_W-1:0]    rsp_tdata
);
   import rrss_pkg::*;

   logic                 rsp_switched;
   logic                 rsp_fork_ok;
   logic [1:0]           rsp_status;
   logic [OUT_IDX_W-1:0] rsp_child;

   assign rsp_status   = rsp_tdata[7:6];
   assign rsp_switched = rsp_tdata[8];
   assign rsp_fork_ok  = rsp_tdata[9];
   assign rsp_child    = rsp_tdata[15:10];

   // stalled response holds
   `RRSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                     rsp_tvalid && $stable(rsp_tdata), "stalled response changed")

   // one transaction at a time: busy right after acceptance
   `RRSS_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready,
                     !req_tready, "ready stayed high after acceptance")

   // failed or absent fork reports slot zero
   `RRSS_ASSERT_HOLDS(a_child_zero, clock, reset,
                      (rsp_tvalid && !rsp_fork_ok) |-> (rsp_child == '0),
                      "child slot set without fork")

   // a switch always lands on a running slot and never comes from a fork
   `RRSS_ASSERT_HOLDS(a_switch_running, clock, reset,
                      (rsp_tvalid && rsp_switched) |-> (rsp_status == ST_RUNNING && !rsp_fork_ok),
                      "switch to a slot not running")

endmodule

bind round_robin_sleep_scheduler rrss_checker u_rrss_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
   import rrss_pkg::*;

   localparam int NUM_SLOTS      = 4;
   localparam int SETTLE_CYCLES  = 12;    // a walk over all slots plus a switch, with margin
   localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
   localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction on either channel

   typedef struct packed {
      logic [5:0] running_slot;
      status_type status;
      logic       switched;
      logic       fork_ok;
      logic [5:0] child_slot;
   } sched_outcome_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [TICKS_W-1:0]   req_tdata = '0;
   logic [KIND_W-1:0]    req_tuser = KIND_TICK;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_we = 1'b0;
   logic [SLICE_W-1:0]   csr_wdata = '0;

   // scheduler state as the testbench sees it
   status_type           slot_state  [NUM_SLOTS];
   logic [15:0]          sleep_count [NUM_SLOTS];
   logic [7:0]           slice_count [NUM_SLOTS];
   int unsigned          cur_slot;
   logic [7:0]           slice_cfg;

   sched_outcome_type    outcomes_due[$];
   int                   mismatches = 0;
   int                   send_idle_pct = 0;
   int                   recv_idle_pct = 0;
   int                   hold_requests = 0;
   int                   hold_served = 0;
   int                   hold_left = 0;
   int                   quiet_cycles = 0;

   round_robin_sleep_scheduler u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // timer tick: count down sleepers, pick the next runnable slot, age and maybe preempt
   function automatic void advance_tick();
      int unsigned cur;
      int unsigned nxt;
      int unsigned k;
      bit          found;
      cur   = cur_slot;
      nxt   = 0;
      found = 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (slot_state[i] == ST_BLOCKED) begin
            sleep_count[i] = sleep_count[i] - 16'd1;
            if (sleep_count[i] == 16'd0) begin
               slot_state[i]  = ST_RUNNABLE;
               slice_count[i] = 8'd0;
            end
         end
      end
      for (int i = 1; i < NUM_SLOTS; i++) begin
         k = (cur + i) % NUM_SLOTS;
         if (!found && slot_state[k] == ST_RUNNABLE) begin
            nxt   = k;
            found = 1'b1;
         end
      end
      if (slot_state[cur] == ST_RUNNING) begin
         slice_count[cur] = slice_count[cur] + 8'd1;
         if (slice_count[cur] >= slice_cfg) begin
            slot_state[cur]  = ST_RUNNABLE;
            slice_count[cur] = 8'd0;
         end
      end
      if (slot_state[cur] != ST_RUNNING && found) begin
         slot_state[nxt] = ST_RUNNING;
         cur = nxt;
      end
      cur_slot = cur;
   endfunction

   function automatic sched_outcome_type apply_event(kind_type k, logic [15:0] ticks);
      sched_outcome_type o;
      int unsigned       origin;
      origin       = cur_slot;
      o.fork_ok    = 1'b0;
      o.child_slot = '0;
      case (k)
         KIND_TICK: begin
            advance_tick();
         end
         KIND_SLEEP: begin
            // a zero-length sleep is dropped without a tick
            if (ticks != 16'd0) begin
               slot_state[origin]  = ST_BLOCKED;
               sleep_count[origin] = ticks;
               advance_tick();
            end
         end
         KIND_EXIT: begin
            slot_state[origin] = ST_DEAD;
            advance_tick();
         end
         default: begin
            // fork never ticks and never claims slot 0
            for (int i = 1; i < NUM_SLOTS; i++) begin
               if (!o.fork_ok && slot_state[i] == ST_DEAD) begin
                  slot_state[i]  = ST_RUNNABLE;
                  slice_count[i] = 8'd0;
                  sleep_count[i] = 16'd0;
                  o.fork_ok      = 1'b1;
                  o.child_slot   = 6'(i);
               end
            end
         end
      endcase
      o.running_slot = 6'(cur_slot);
      o.status       = slot_state[cur_slot];
      o.switched     = (cur_slot != origin);
      return o;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // send one event, with a random gap in front of it
   task automatic post_event(kind_type k, logic [15:0] ticks);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= k;
      req_tdata  <= ticks;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      outcomes_due.push_back(apply_event(k, ticks));
   endtask

   // wait for every outstanding response, then let the walk finish
   task automatic settle();
      req_tvalid <= 1'b0;
      while (outcomes_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_slice(logic [7:0] value);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      slice_cfg  = value;
   endtask

   function automatic logic [15:0] pick_sleep_ticks();
      int r;
      r = $urandom_range(99);
      if (r < 8)
         return 16'd0;
      else if (r < 70)
         return 16'($urandom_range(6, 1));
      else if (r < 90)
         return 16'($urandom_range(40, 7));
      return 16'($urandom);
   endfunction

   function automatic kind_type pick_kind();
      int r;
      r = $urandom_range(99);
      if (r < 45)
         return KIND_TICK;
      else if (r < 65)
         return KIND_SLEEP;
      else if (r < 75)
         return KIND_EXIT;
      return KIND_FORK;
   endfunction

   // fill the table, a failing fork, zero sleep, one-tick sleep, longest sleep
   task automatic test_fork_and_sleep();
      post_event(KIND_TICK, 16'hFFFF);
      post_event(KIND_FORK, 16'h0000);
      post_event(KIND_FORK, 16'hFFFF);
      post_event(KIND_FORK, 16'h5A5A);
      post_event(KIND_FORK, 16'hA5A5);
      post_event(KIND_SLEEP, 16'd0);
      post_event(KIND_SLEEP, 16'd1);
      post_event(KIND_EXIT, 16'h1234);
      post_event(KIND_SLEEP, 16'hFFFF);
      post_event(KIND_TICK, 16'd0);
      post_event(KIND_FORK, 16'd0);
   endtask

   // zero slice preempts on every tick
   task automatic test_zero_slice();
      set_slice(8'd0);
      repeat (3) post_event(KIND_TICK, 16'd0);
   endtask

   // exits until nothing can run, then a sleep on the dead current slot
   task automatic test_exit_without_successor();
      repeat (4) post_event(KIND_EXIT, 16'd0);
      post_event(KIND_SLEEP, 16'd3);
      post_event(KIND_TICK, 16'd0);
      post_event(KIND_TICK, 16'd0);
   endtask

   // a lone task preempted with nobody to switch to stays current as runnable
   task automatic test_lone_preempted();
      set_slice(8'd1);
      post_event(KIND_TICK, 16'd0);
      post_event(KIND_TICK, 16'd0);
      post_event(KIND_FORK, 16'd0);
      post_event(KIND_TICK, 16'd0);
   endtask

   task automatic test_random_mix(int count, int sidle, int ridle, logic [7:0] slice);
      set_slice(slice);
      send_idle_pct = sidle;
      recv_idle_pct = ridle;
      repeat (count) post_event(pick_kind(), pick_sleep_ticks());
   endtask

   // receiver holds off while events keep coming, so the block stalls its input
   task automatic test_backpressure();
      settle();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests++;
      repeat (30) post_event(pick_kind(), pick_sleep_ticks());
   endtask

   // receiver: random stalls, plus a long hold-off counted here
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         rsp_tready  <= 1'b0;
         hold_left   <= HOLD_CYCLES;
         hold_served <= hold_requests;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : rsp_check
      sched_outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (outcomes_due.size() == 0) begin
            $display("%0t: response with no event pending, expected none, actual %h",
                     $time, rsp_tdata);
            mismatches++;
         end else begin
            want = outcomes_due.pop_front();
            check_field("running_slot", want.running_slot, rsp_tdata[5:0]);
            check_field("current_status", want.status, rsp_tdata[7:6]);
            check_field("switched", want.switched, rsp_tdata[8]);
            check_field("fork_ok", want.fork_ok, rsp_tdata[9]);
            check_field("child_slot", want.child_slot, rsp_tdata[15:10]);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         slot_state[i]  = ST_DEAD;
         sleep_count[i] = 16'd0;
         slice_count[i] = 8'd0;
      end
      slot_state[0] = ST_RUNNING;
      cur_slot      = 0;
      slice_cfg     = SLICE_RESET;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 29;
      recv_idle_pct = 60;
      test_fork_and_sleep();
      test_zero_slice();
      test_exit_without_successor();
      test_lone_preempted();

      test_random_mix(170, 29, 60, 8'd1);
      test_random_mix(110, 29, 60, 8'd0);
      test_random_mix(170, 60, 29, 8'd255);
      test_random_mix(110, 60, 29, 8'($urandom_range(12, 2)));
      test_random_mix(120, 0, 0, 8'd3);
      test_random_mix(120, 0, 0, 8'($urandom_range(255, 0)));
      test_backpressure();

      settle();
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/rrss_pkg.sv
hw/rtl/rrss_slot_alu.sv
hw/rtl/rrss_slot_mem.sv
hw/rtl/round_robin_sleep_scheduler.sv
hw/rtl/rrss_checker.sv
sim/tb.sv
